>>> rtl/assert_macros.svh
// Assertion macros used by flat_face_shading_cull.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ffsc_pkg.sv
`default_nettype none
package ffsc_pkg;

	localparam int SQRT_LAT = 32;
	localparam int DIV_LAT = 15;
	localparam int MAG_W = 66;
	localparam int M_W = 31;

	typedef struct packed {
		logic signed [31:0] v0_x;
		logic signed [31:0] v0_y;
		logic signed [31:0] v0_z;
		logic signed [31:0] v1_x;
		logic signed [31:0] v1_y;
		logic signed [31:0] v1_z;
		logic signed [31:0] v2_x;
		logic signed [31:0] v2_y;
		logic signed [31:0] v2_z;
	} in_item_t;

	typedef struct packed {
		logic               visible;
		logic [7:0]         shade;
		logic signed [31:0] depth;
		logic               degenerate;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} out_item_t;

	typedef enum logic [2:0] {
		REG_LIGHT_X = 3'd0,
		REG_LIGHT_Y = 3'd1,
		REG_LIGHT_Z = 3'd2,
		REG_FOCAL   = 3'd3,
		REG_BASE    = 3'd4,
		REG_SPAN    = 3'd5,
		REG_ALWAYS  = 3'd6
	} cfg_reg_t;

	function automatic logic [6:0] topbit(input logic [MAG_W-1:0] v);
		logic [6:0] p;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) begin
				p = 7'(i);
			end
		end
		return p;
	endfunction

endpackage
`default_nettype wire

>>> rtl/flat_face_shading_cull.sv
// Flat face shading with back-face culling.
//
// The in channel takes one face (three vertices, signed Q16.16) per
// transaction; the out channel returns its visibility, palette index, depth
// and unit normal in Q2.14. The cfg channel writes the light, focal length,
// color range and always-visible registers; it is always ready and should
// only be used while no face is in flight.
//
// The datapath is a 60-stage pipeline: edge vectors, cross product,
// normalizing shift, sum of squares, a 32-stage square root, three 15-stage
// dividers, then the culling test and lighting. One face per cycle is
// sustained while the receiver takes results without stalling.
//
// Reset clears all valid bits and loads the register defaults. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops until the result is taken; nothing is dropped or repeated.
`default_nettype none
`include "assert_macros.svh"
module flat_face_shading_cull #(
	parameter int EPSILON_LSB = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ffsc_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ffsc_pkg::out_item_t     out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int NSTG = 8 + ffsc_pkg::SQRT_LAT + ffsc_pkg::DIV_LAT + 5;
	localparam int DLY = ffsc_pkg::SQRT_LAT + ffsc_pkg::DIV_LAT;
	localparam logic signed [50:0] EPS = 51'(EPSILON_LSB * 16384);

	typedef struct packed {
		logic signed [31:0] v0x;
		logic signed [31:0] v0y;
		logic signed [32:0] vzf;
		logic signed [31:0] depth;
	} vert_t;

	typedef struct packed {
		vert_t       vt;
		logic [30:0] m0;
		logic [30:0] m1;
		logic [30:0] m2;
		logic [2:0]  neg;
		logic        degen;
	} side_t;

	logic signed [15:0] light_x_q, light_y_q, light_z_q;
	logic [30:0]        focal_q;
	logic [7:0]         color_base_q, color_span_q;
	logic               always_vis_q;

	logic            adv;
	logic [NSTG-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			light_z_q <= 16'sd16384;
			focal_q <= 31'd65536;
			color_base_q <= '0;
			color_span_q <= '0;
			always_vis_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (ffsc_pkg::cfg_reg_t'(cfg_index))
				ffsc_pkg::REG_LIGHT_X: light_x_q <= cfg_data[15:0];
				ffsc_pkg::REG_LIGHT_Y: light_y_q <= cfg_data[15:0];
				ffsc_pkg::REG_LIGHT_Z: light_z_q <= cfg_data[15:0];
				ffsc_pkg::REG_FOCAL:   focal_q <= cfg_data[30:0];
				ffsc_pkg::REG_BASE:    color_base_q <= cfg_data[7:0];
				ffsc_pkg::REG_SPAN:    color_span_q <= cfg_data[7:0];
				ffsc_pkg::REG_ALWAYS:  always_vis_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign adv = !vld_q[NSTG-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_valid};
		end
	end

	logic signed [32:0] a_s1 [3];
	logic signed [32:0] b_s1 [3];
	vert_t              vt_s1, vt_s2, vt_s3, vt_s4, vt_s5, vt_s6, vt_s7;
	logic signed [65:0] p_s2 [6];
	logic signed [66:0] c_s3 [3];
	logic [ffsc_pkg::MAG_W-1:0] mag_s4 [3];
	logic [ffsc_pkg::MAG_W-1:0] mag_s5 [3];
	logic [2:0]         neg_s4, neg_s5, neg_s6, neg_s7;
	logic [6:0]         pos_s5;
	logic               degen_s5, degen_s6, degen_s7;
	logic [30:0]        m_s6 [3];
	logic [30:0]        m_s7 [3];
	logic [61:0]        sq_s7 [3];
	logic [63:0]        sum_s8;
	side_t              side_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1[0] <= 33'(in_data.v1_x) - 33'(in_data.v0_x);
			a_s1[1] <= 33'(in_data.v1_y) - 33'(in_data.v0_y);
			a_s1[2] <= 33'(in_data.v1_z) - 33'(in_data.v0_z);
			b_s1[0] <= 33'(in_data.v1_x) - 33'(in_data.v2_x);
			b_s1[1] <= 33'(in_data.v1_y) - 33'(in_data.v2_y);
			b_s1[2] <= 33'(in_data.v1_z) - 33'(in_data.v2_z);
			vt_s1.v0x <= in_data.v0_x;
			vt_s1.v0y <= in_data.v0_y;
			vt_s1.vzf <= 33'(in_data.v0_z) + $signed({2'b00, focal_q});
			vt_s1.depth <= in_data.v0_z;

			p_s2[0] <= 66'(a_s1[1] * b_s1[2]);
			p_s2[1] <= 66'(a_s1[2] * b_s1[1]);
			p_s2[2] <= 66'(a_s1[2] * b_s1[0]);
			p_s2[3] <= 66'(a_s1[0] * b_s1[2]);
			p_s2[4] <= 66'(a_s1[0] * b_s1[1]);
			p_s2[5] <= 66'(a_s1[1] * b_s1[0]);
			vt_s2 <= vt_s1;

			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= 67'(p_s2[2*i]) - 67'(p_s2[2*i+1]);
			end
			vt_s3 <= vt_s2;

			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= c_s3[i][66];
				mag_s4[i] <= c_s3[i][66] ? 66'(-c_s3[i]) : c_s3[i][65:0];
			end
			vt_s4 <= vt_s3;

			pos_s5 <= ffsc_pkg::topbit(mag_s4[0] | mag_s4[1] | mag_s4[2]);
			degen_s5 <= ((mag_s4[0] | mag_s4[1] | mag_s4[2]) == '0);
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			vt_s5 <= vt_s4;

			for (int i = 0; i < 3; i++) begin
				m_s6[i] <= (pos_s5 > 7'd30) ? 31'(mag_s5[i] >> (pos_s5 - 7'd30))
					: 31'(mag_s5[i] << (7'd30 - pos_s5));
			end
			neg_s6 <= neg_s5;
			degen_s6 <= degen_s5;
			vt_s6 <= vt_s5;

			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= m_s6[i] * m_s6[i];
			end
			m_s7 <= m_s6;
			neg_s7 <= neg_s6;
			degen_s7 <= degen_s6;
			vt_s7 <= vt_s6;

			sum_s8 <= 64'(sq_s7[0]) + 64'(sq_s7[1]) + 64'(sq_s7[2]);
			side_s8.vt <= vt_s7;
			side_s8.m0 <= m_s7[0];
			side_s8.m1 <= m_s7[1];
			side_s8.m2 <= m_s7[2];
			side_s8.neg <= neg_s7;
			side_s8.degen <= degen_s7;
		end
	end

	side_t       dly_q [DLY];
	logic [31:0] root;
	logic [14:0] quo [3];
	side_t       tap;

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_q[0] <= side_s8;
			for (int i = 1; i < DLY; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	ffsc_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.s_in (sum_s8),
		.root (root)
	);

	assign tap = dly_q[ffsc_pkg::SQRT_LAT-1];

	ffsc_div u_div0 (.clk(clk), .en(adv), .m_in(tap.m0), .q_in(root), .quo(quo[0]));
	ffsc_div u_div1 (.clk(clk), .en(adv), .m_in(tap.m1), .q_in(root), .quo(quo[1]));
	ffsc_div u_div2 (.clk(clk), .en(adv), .m_in(tap.m2), .q_in(root), .quo(quo[2]));

	side_t              last;
	logic signed [15:0] n_s9 [3];
	logic signed [15:0] n_s10 [3];
	logic signed [15:0] n_s11 [3];
	logic signed [15:0] n_s12 [3];
	vert_t              vt_s9;
	logic               degen_s9, degen_s10, degen_s11, degen_s12;
	logic signed [31:0] depth_s10, depth_s11, depth_s12;
	logic signed [48:0] pd_s10 [3];
	logic signed [31:0] pl_s10 [3];
	logic signed [50:0] dsum;
	logic               vis_s11, vis_s12;
	logic signed [33:0] dl_s11;
	logic [40:0]        mul_s12;
	logic [8:0]         cap_s12;
	logic [13:0]        raw;

	assign last = dly_q[DLY-1];
	assign dsum = 51'(pd_s10[0]) + 51'(pd_s10[1]) + 51'(pd_s10[2]);
	assign raw = 14'(color_base_q) + 14'(mul_s12[40:28]);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (last.degen) begin
					n_s9[i] <= '0;
				end else if (last.neg[i]) begin
					n_s9[i] <= -$signed({1'b0, quo[i]});
				end else begin
					n_s9[i] <= $signed({1'b0, quo[i]});
				end
			end
			vt_s9 <= last.vt;
			degen_s9 <= last.degen;

			pd_s10[0] <= 49'(n_s9[0] * vt_s9.v0x);
			pd_s10[1] <= 49'(n_s9[1] * vt_s9.v0y);
			pd_s10[2] <= 49'(n_s9[2] * vt_s9.vzf);
			pl_s10[0] <= 32'(n_s9[0] * light_x_q);
			pl_s10[1] <= 32'(n_s9[1] * light_y_q);
			pl_s10[2] <= 32'(n_s9[2] * light_z_q);
			n_s10 <= n_s9;
			degen_s10 <= degen_s9;
			depth_s10 <= vt_s9.depth;

			vis_s11 <= !degen_s10 && (always_vis_q || (dsum < EPS));
			dl_s11 <= 34'(pl_s10[0]) + 34'(pl_s10[1]) + 34'(pl_s10[2]);
			n_s11 <= n_s10;
			degen_s11 <= degen_s10;
			depth_s11 <= depth_s10;

			mul_s12 <= 41'(dl_s11[33] ? 33'(-dl_s11) : dl_s11[32:0]) * 41'(color_span_q);
			cap_s12 <= ((9'(color_base_q) + 9'(color_span_q)) > 9'd255) ? 9'd255
				: 9'(color_base_q) + 9'(color_span_q);
			vis_s12 <= vis_s11;
			n_s12 <= n_s11;
			degen_s12 <= degen_s11;
			depth_s12 <= depth_s11;

			out_data.visible <= vis_s12;
			out_data.shade <= !vis_s12 ? color_base_q
				: ((raw > 14'(cap_s12)) ? cap_s12[7:0] : raw[7:0]);
			out_data.depth <= depth_s12;
			out_data.degenerate <= degen_s12;
			out_data.normal_x <= n_s12[0];
			out_data.normal_y <= n_s12[1];
			out_data.normal_z <= n_s12[2];
		end
	end

	`ASSERT_IMPLIES(a_degen_hidden, clk, arst_n, out_valid && out_data.degenerate, !out_data.visible && out_data.normal_x == 16'sd0 && out_data.normal_z == 16'sd0)
	`ASSERT_IMPLIES(a_hidden_base, clk, arst_n, out_valid && !out_data.visible, out_data.shade == color_base_q)
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, vld_q == $past(vld_q))

endmodule
`default_nettype wire

>>> rtl/ffsc_sqrt.sv
`default_nettype none
module ffsc_sqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] s_in,
	output logic      [31:0] root
);

	logic [63:0] sv_s   [1:ffsc_pkg::SQRT_LAT];
	logic [33:0] rem_s  [1:ffsc_pkg::SQRT_LAT];
	logic [31:0] root_s [1:ffsc_pkg::SQRT_LAT];

	for (genvar k = 0; k < ffsc_pkg::SQRT_LAT; k++) begin : g_step
		logic [63:0] sv_c;
		logic [33:0] rem_c;
		logic [31:0] root_c;
		logic [35:0] r2;
		logic [35:0] t;
		logic        ge;
		if (k == 0) begin : g_first
			assign sv_c = s_in;
			assign rem_c = '0;
			assign root_c = '0;
		end else begin : g_next
			assign sv_c = sv_s[k];
			assign rem_c = rem_s[k];
			assign root_c = root_s[k];
		end
		always_comb begin
			r2 = {rem_c, sv_c[63:62]};
			t = {2'b00, root_c, 2'b01};
			ge = (r2 >= t);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? 34'(r2 - t) : r2[33:0];
				root_s[k+1] <= {root_c[30:0], ge};
				sv_s[k+1] <= {sv_c[61:0], 2'b00};
			end
		end
	end

	assign root = root_s[ffsc_pkg::SQRT_LAT];

endmodule
`default_nettype wire

>>> rtl/ffsc_div.sv
`default_nettype none
module ffsc_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [30:0] m_in,
	input  wire logic [31:0] q_in,
	output logic      [14:0] quo
);

	logic [45:0] num;
	logic [31:0] rem_s [1:ffsc_pkg::DIV_LAT];
	logic [14:0] low_s [1:ffsc_pkg::DIV_LAT];
	logic [14:0] quo_s [1:ffsc_pkg::DIV_LAT];
	logic [31:0] d_s   [1:ffsc_pkg::DIV_LAT];

	assign num = {1'b0, m_in, 14'd0} + 46'(q_in[31:1]);

	for (genvar k = 0; k < ffsc_pkg::DIV_LAT; k++) begin : g_step
		logic [31:0] rem_c;
		logic [14:0] low_c;
		logic [14:0] quo_c;
		logic [31:0] d_c;
		logic [32:0] r2;
		logic [32:0] dd;
		logic        ge;
		if (k == 0) begin : g_first
			assign rem_c = {1'b0, num[45:15]};
			assign low_c = num[14:0];
			assign quo_c = '0;
			assign d_c = q_in;
		end else begin : g_next
			assign rem_c = rem_s[k];
			assign low_c = low_s[k];
			assign quo_c = quo_s[k];
			assign d_c = d_s[k];
		end
		always_comb begin
			r2 = {rem_c, low_c[14]};
			dd = {1'b0, d_c};
			ge = (r2 >= dd);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? 32'(r2 - dd) : r2[31:0];
				low_s[k+1] <= {low_c[13:0], 1'b0};
				quo_s[k+1] <= {quo_c[13:0], ge};
				d_s[k+1] <= d_c;
			end
		end
	end

	assign quo = quo_s[ffsc_pkg::DIV_LAT];

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int EPS_LSB = 1;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ffsc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ffsc_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	flat_face_shading_cull #(.EPSILON_LSB(EPS_LSB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic signed [15:0] lx_m, ly_m, lz_m;
	logic [30:0] focal_m;
	logic [7:0] base_m, span_m;
	logic always_m;

	ffsc_pkg::in_item_t pending_faces[$];
	ffsc_pkg::out_item_t shaded_faces[$];
	int mismatches = 0;
	int faces_in = 0;
	int faces_out = 0;
	int visible_seen = 0;
	int degen_seen = 0;
	int idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] root64(logic [63:0] s);
		logic [63:0] res, bitv;
		res = 64'd0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 64'd0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic ffsc_pkg::out_item_t shade_face(ffsc_pkg::in_item_t f);
		longint v[9];
		logic signed [71:0] ea[3], eb[3], cr[3];
		logic [71:0] mag[3], orv;
		logic negs[3];
		logic [63:0] m[3], ssq, q, k, s, add, cap, sh;
		longint nrm[3];
		longint d, dl;
		int p;
		logic degen, vis;
		ffsc_pkg::out_item_t r;
		v[0] = f.v0_x; v[1] = f.v0_y; v[2] = f.v0_z;
		v[3] = f.v1_x; v[4] = f.v1_y; v[5] = f.v1_z;
		v[6] = f.v2_x; v[7] = f.v2_y; v[8] = f.v2_z;
		for (int i = 0; i < 3; i++) begin
			ea[i] = v[3+i] - v[i];
			eb[i] = v[3+i] - v[6+i];
		end
		cr[0] = ea[1] * eb[2] - ea[2] * eb[1];
		cr[1] = ea[2] * eb[0] - ea[0] * eb[2];
		cr[2] = ea[0] * eb[1] - ea[1] * eb[0];
		for (int i = 0; i < 3; i++) begin
			negs[i] = cr[i] < 0;
			mag[i] = negs[i] ? -cr[i] : cr[i];
			nrm[i] = 0;
		end
		orv = mag[0] | mag[1] | mag[2];
		degen = (orv == 72'd0);
		vis = 1'b0;
		sh = base_m;
		if (!degen) begin
			p = 0;
			for (int i = 0; i < 72; i++)
				if (orv[i])
					p = i;
			ssq = 64'd0;
			for (int i = 0; i < 3; i++) begin
				if (p > 30)
					m[i] = 64'(mag[i] >> (p - 30));
				else
					m[i] = 64'(mag[i] << (30 - p));
				ssq = ssq + m[i] * m[i];
			end
			q = root64(ssq);
			for (int i = 0; i < 3; i++) begin
				k = (m[i] * 64'd16384 + q / 2) / q;
				nrm[i] = negs[i] ? -longint'(k) : longint'(k);
			end
			d = nrm[0] * v[0] + nrm[1] * v[1] + nrm[2] * (v[2] + longint'(focal_m));
			vis = always_m || (d < (longint'(EPS_LSB) << 14));
		end
		if (vis) begin
			dl = nrm[0] * longint'(lx_m) + nrm[1] * longint'(ly_m) + nrm[2] * longint'(lz_m);
			s = dl < 0 ? -dl : dl;
			add = (s * span_m) >> 28;
			cap = base_m + span_m;
			if (cap > 64'd255)
				cap = 64'd255;
			sh = base_m + add;
			if (sh > cap)
				sh = cap;
		end
		r.visible = vis;
		r.shade = sh[7:0];
		r.depth = f.v0_z;
		r.degenerate = degen;
		r.normal_x = nrm[0][15:0];
		r.normal_y = nrm[1][15:0];
		r.normal_z = nrm[2][15:0];
		return r;
	endfunction

	function automatic ffsc_pkg::in_item_t face_of(logic [31:0] a0, logic [31:0] a1,
			logic [31:0] a2, logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
			logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
		ffsc_pkg::in_item_t f;
		f = {a0, a1, a2, b0, b1, b2, c0, c1, c2};
		return f;
	endfunction

	function automatic logic [31:0] coord(int kind);
		logic [31:0] x;
		case (kind)
			0: x = $urandom;
			1: x = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			2: x = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			default: x = ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
		endcase
		return x;
	endfunction

	function automatic ffsc_pkg::in_item_t random_face();
		ffsc_pkg::in_item_t f;
		int kind, shape;
		kind = $urandom_range(0, 9);
		kind = kind < 4 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3;
		f = face_of(coord(kind), coord(kind), coord(kind), coord(kind), coord(kind),
			coord(kind), coord(kind), coord(kind), coord(kind));
		shape = $urandom_range(0, 15);
		if (shape == 0) begin
			f.v2_x = f.v0_x; f.v2_y = f.v0_y; f.v2_z = f.v0_z;
		end else if (shape == 1) begin
			f.v2_x = f.v1_x; f.v2_y = f.v1_y; f.v2_z = f.v1_z;
		end else if (shape == 2) begin
			f.v2_x = 2 * f.v1_x - f.v0_x;
			f.v2_y = 2 * f.v1_y - f.v0_y;
			f.v2_z = 2 * f.v1_z - f.v0_z;
		end
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic fire;
		int burst_left, gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			fire = in_valid && in_ready;
			if (fire) begin
				shaded_faces.push_back(shade_face(in_data));
				void'(pending_faces.pop_front());
				faces_in++;
			end
			if (!in_valid || fire) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_faces.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_faces[0];
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		ffsc_pkg::out_item_t want;
		int mode, mode_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			mode = 0;
			mode_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				faces_out++;
				if (out_data.visible)
					visible_seen++;
				if (out_data.degenerate)
					degen_seen++;
				if (shaded_faces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: %h", out_data);
				end else begin
					want = shaded_faces.pop_front();
					if (out_data.visible !== want.visible || out_data.shade !== want.shade ||
							out_data.depth !== want.depth ||
							out_data.degenerate !== want.degenerate ||
							out_data.normal_x !== want.normal_x ||
							out_data.normal_y !== want.normal_y ||
							out_data.normal_z !== want.normal_z) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected vis=%b shade=%0d depth=%h deg=%b n=(%0d,%0d,%0d)",
								want.visible, want.shade, want.depth, want.degenerate,
								want.normal_x, want.normal_y, want.normal_z);
							$display("          actual   vis=%b shade=%0d depth=%h deg=%b n=(%0d,%0d,%0d)",
								out_data.visible, out_data.shade, out_data.depth,
								out_data.degenerate, out_data.normal_x, out_data.normal_y,
								out_data.normal_z);
						end
					end
				end
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= mode_left[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ffsc_pkg::REG_LIGHT_X: lx_m = val[15:0];
			ffsc_pkg::REG_LIGHT_Y: ly_m = val[15:0];
			ffsc_pkg::REG_LIGHT_Z: lz_m = val[15:0];
			ffsc_pkg::REG_FOCAL: focal_m = val[30:0];
			ffsc_pkg::REG_BASE: base_m = val[7:0];
			ffsc_pkg::REG_SPAN: span_m = val[7:0];
			ffsc_pkg::REG_ALWAYS: always_m = val[0];
			default: ;
		endcase
	endtask

	task automatic load_setup(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
			logic [30:0] fo, logic [7:0] ba, logic [7:0] sp, logic al);
		cfg_write(ffsc_pkg::REG_LIGHT_X, {16'($urandom_range(0, 65535)), lx});
		cfg_write(ffsc_pkg::REG_LIGHT_Y, {16'($urandom_range(0, 65535)), ly});
		cfg_write(ffsc_pkg::REG_LIGHT_Z, {16'($urandom_range(0, 65535)), lz});
		cfg_write(ffsc_pkg::REG_FOCAL, {1'($urandom_range(0, 1)), fo});
		cfg_write(ffsc_pkg::REG_BASE, {24'($urandom), ba});
		cfg_write(ffsc_pkg::REG_SPAN, {24'($urandom), sp});
		cfg_write(ffsc_pkg::REG_ALWAYS, {31'($urandom), al});
		cfg_write(CFG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_faces.size() > 0 || shaded_faces.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		lx_m = 16'sd0; ly_m = 16'sd0; lz_m = 16'sd16384;
		focal_m = 31'd65536; base_m = 8'd0; span_m = 8'd0; always_m = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ;
				1: load_setup(16'h8000, 16'h7fff, 16'h8000, 31'd0, 8'd0, 8'd255, 1'b1);
				2: load_setup(16'h0000, 16'h0000, 16'h7fff, 31'h7fffffff, 8'd255, 8'd255, 1'b0);
				3: load_setup(16'h2000, 16'he000, 16'h3000, 31'd65536, 8'd16, 8'd200, 1'b0);
				default: load_setup(16'($urandom), 16'($urandom), 16'($urandom),
					31'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
			endcase
			if (ph < 3) begin
				pending_faces.push_back('0);
				pending_faces.push_back({9{32'h7fffffff}});
				pending_faces.push_back({9{32'h80000000}});
				pending_faces.push_back(face_of(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
				pending_faces.push_back(face_of(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0));
				pending_faces.push_back(face_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
				pending_faces.push_back(face_of(32'h80000000, 32'h80000000, 32'h80000000,
					32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
					32'h80000000));
				pending_faces.push_back(face_of(32'h7fffffff, 32'h80000000, 32'h7fffffff,
					32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
					32'h80000000));
				pending_faces.push_back(face_of(0, 0, 32'h100000, 32'h10000, 0, 32'h100000,
					0, 32'h10000, 32'h100000));
				pending_faces.push_back(face_of(1, 2, 3, 2, 4, 6, 3, 6, 9));
				pending_faces.push_back(face_of(5, 5, 5, 9, 9, 9, 9, 9, 9));
				pending_faces.push_back(face_of(0, 0, 32'hffff0000, 0, 32'h10000, 32'hffff0000,
					32'h10000, 0, 32'hffff0000));
			end
			for (int i = 0; i < 160; i++)
				pending_faces.push_back(random_face());
			drain();
		end
		$display("Ran %0d faces through seven register setups; %0d visible, %0d degenerate.",
			faces_in, visible_seen, degen_seen);
		$display("Results checked: %0d, mismatches: %0d.", faces_out, mismatches);
		if (mismatches == 0 && shaded_faces.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/ffsc_pkg.sv
rtl/ffsc_sqrt.sv
rtl/ffsc_div.sv
rtl/flat_face_shading_cull.sv
tb/testbench.sv
